FILE: rtl/es_descriptor_classifier_macros.svh
// Assertion helpers shared by esdc_front and esdc_queue.
`ifndef ES_DESCRIPTOR_CLASSIFIER_MACROS_SVH
`define ES_DESCRIPTOR_CLASSIFIER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ESDC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ESDC_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: rtl/esdc_pkg.sv
`default_nettype none
package esdc_pkg;

    localparam logic [7:0] TAG_TTX  = 8'h56;
    localparam logic [7:0] TAG_SUB  = 8'h59;
    localparam logic [7:0] TAG_AC3  = 8'h6A;
    localparam logic [7:0] TAG_EAC3 = 8'h7A;
    localparam logic [7:0] TAG_AIT  = 8'h6F;
    localparam logic [7:0] TAG_LANG = 8'h0A;

    localparam logic [7:0] SK_MPEG1V = 8'h01;
    localparam logic [7:0] SK_MPEG2V = 8'h02;
    localparam logic [7:0] SK_MPEG1A = 8'h03;
    localparam logic [7:0] SK_MPEG2A = 8'h04;
    localparam logic [7:0] SK_PRIV   = 8'h05;
    localparam logic [7:0] SK_PES    = 8'h06;
    localparam logic [7:0] SK_AAC    = 8'h0F;
    localparam logic [7:0] SK_LATM   = 8'h11;
    localparam logic [7:0] SK_H264   = 8'h1B;
    localparam logic [7:0] SK_HEVC   = 8'h24;
    localparam logic [7:0] SK_AC3    = 8'h81;
    localparam logic [7:0] SK_EAC3   = 8'h87;

    localparam logic [2:0] CLS_DATA = 3'd0;
    localparam logic [2:0] CLS_VID  = 3'd1;
    localparam logic [2:0] CLS_AUD  = 3'd2;
    localparam logic [2:0] CLS_TTX  = 3'd3;
    localparam logic [2:0] CLS_SUB  = 3'd4;
    localparam logic [2:0] CLS_AIT  = 3'd5;

    localparam logic [3:0] COD_NONE = 4'd0;
    localparam logic [3:0] COD_M2V  = 4'd1;
    localparam logic [3:0] COD_H264 = 4'd2;
    localparam logic [3:0] COD_HEVC = 4'd3;
    localparam logic [3:0] COD_MP2A = 4'd4;
    localparam logic [3:0] COD_AAC  = 4'd5;
    localparam logic [3:0] COD_LATM = 4'd6;
    localparam logic [3:0] COD_AC3  = 4'd7;
    localparam logic [3:0] COD_EAC3 = 4'd8;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_BODY
    } phase_t;

    // Everything the back end needs to build one result.
    typedef struct packed {
        logic [7:0]  kind;
        logic        f_ttx;
        logic        f_sub;
        logic        f_ac3;
        logic        f_eac3;
        logic        f_ait;
        logic        sub_valid;
        logic        lang_valid;
        logic [39:0] ttx;
        logic [63:0] sub;
        logic [23:0] lang;
    } summary_t;

    typedef struct packed {
        logic [2:0]  stream_class;
        logic [3:0]  codec_id;
        logic [23:0] language;
        logic [9:0]  teletext_page;
        logic [4:0]  teletext_kind;
        logic [23:0] teletext_language;
        logic [7:0]  subtitle_kind;
        logic [15:0] composition_page;
        logic [15:0] ancillary_page;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/es_descriptor_classifier.sv
// A stream's summary enters the queue when its last byte is taken and reaches out_valid via the output register.
// Throughput: one descriptor byte per cycle; the input stalls only while the queue is full.
// A two-entry summary queue and an output register let the back end stall alone.
// Reset (rst_n, async active low) clears parser state, queue pointers and out_valid.
`default_nettype none
module es_descriptor_classifier
    import esdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  stream_kind,
    input  wire logic [7:0]  data_byte,
    input  wire logic        no_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       stream_class,
    output logic [3:0]       codec_id,
    output logic [23:0]      language,
    output logic [9:0]       teletext_page,
    output logic [4:0]       teletext_kind,
    output logic [23:0]      teletext_language,
    output logic [7:0]       subtitle_kind,
    output logic [15:0]      composition_page,
    output logic [15:0]      ancillary_page
);

    summary_t sum_word, head_word;
    result_t  res;
    logic     sum_push, full, not_empty, pop, in_take;

    assign in_stall = full;
    assign in_take  = in_valid && !full;

    esdc_front u_front (
        .clk, .rst_n, .in_take, .stream_kind, .data_byte, .no_byte, .last_byte,
        .sum_word, .sum_push
    );

    esdc_queue #(.DEPTH(DEPTH)) u_queue (
        .clk, .rst_n, .push(sum_push), .push_word(sum_word), .full, .not_empty,
        .pop, .head_word
    );

    esdc_back u_back (
        .clk, .rst_n, .head_word, .head_valid(not_empty), .pop, .out_stall,
        .out_valid, .out_word(res)
    );

    assign stream_class      = res.stream_class;
    assign codec_id          = res.codec_id;
    assign language          = res.language;
    assign teletext_page     = res.teletext_page;
    assign teletext_kind     = res.teletext_kind;
    assign teletext_language = res.teletext_language;
    assign subtitle_kind     = res.subtitle_kind;
    assign composition_page  = res.composition_page;
    assign ancillary_page    = res.ancillary_page;

endmodule
`default_nettype wire

FILE: rtl/esdc_front.sv
`default_nettype none
`include "es_descriptor_classifier_macros.svh"
module esdc_front
    import esdc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_take,
    input  wire logic [7:0] stream_kind,
    input  wire logic [7:0] data_byte,
    input  wire logic     no_byte,
    input  wire logic     last_byte,
    output summary_t      sum_word,
    output logic          sum_push
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  idx_reg, idx_next;
    logic [5:0]  found_reg, found_next;
    logic [31:0] ebuf_reg, ebuf_next;
    logic [63:0] pend_reg, pend_next;
    logic [39:0] ttx_reg, ttx_next;
    logic [63:0] sub_reg, sub_next;
    logic [23:0] lang_reg, lang_next;
    logic        subv_reg, subv_next;
    logic        langv_reg, langv_next;
    logic [2:0]  pos_reg, pos_next;

    logic [5:0]  mask;
    logic        active;
    logic        commit;
    logic [7:0]  commit_len;
    logic [7:0]  idx_inc;
    logic [2:0]  mag;
    logic [4:0]  ty;
    logic [9:0]  page;
    logic        pref;

    always_comb
    begin
        case (tag_reg)
            TAG_TTX:  mask = 6'b000001;
            TAG_SUB:  mask = 6'b000010;
            TAG_AC3:  mask = 6'b000100;
            TAG_EAC3: mask = 6'b001000;
            TAG_AIT:  mask = 6'b010000;
            TAG_LANG: mask = 6'b100000;
            default:  mask = 6'b000000;
        endcase
    end

    assign active  = (mask != 6'd0) && ((found_reg & mask) == 6'd0);
    assign idx_inc = idx_reg + 8'd1;
    assign mag     = ebuf_reg[2:0];
    assign ty      = ebuf_reg[7:3];
    assign page    = 10'((mag == 3'd0) ? 4'd8 : {1'b0, mag}) * 10'd100
                   + 10'(data_byte[7:4]) * 10'd10 + 10'(data_byte[3:0]);
    assign pref    = (ty == 5'd2) || (ty == 5'd5);

    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        ebuf_next  = ebuf_reg;
        pend_next  = pend_reg;
        ttx_next   = ttx_reg;
        sub_next   = sub_reg;
        lang_next  = lang_reg;
        subv_next  = subv_reg;
        langv_next = langv_reg;
        pos_next   = pos_reg;
        commit     = 1'b0;
        commit_len = len_reg;
        if (in_take && !no_byte)
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    tag_next   = data_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = data_byte;
                    idx_next   = 8'd0;
                    pos_next   = 3'd0;
                    ebuf_next  = 32'd0;
                    pend_next  = 64'd0;
                    commit_len = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        commit     = 1'b1;
                        phase_next = PH_TAG;
                    end
                    else
                        phase_next = PH_BODY;
                end
                default:
                begin
                    if (active)
                    begin
                        if (mask[0] && !pend_reg[39])
                        begin
                            if (pos_reg != 3'd4)
                                ebuf_next = {ebuf_reg[23:0], data_byte};
                            else
                            begin
                                if (pend_reg[38:29] == 10'd0 || pref)
                                    pend_next = {24'd0, pref, page, ty, ebuf_reg[31:8]};
                                else if (pref)
                                    pend_next[39] = 1'b1;
                                ebuf_next = 32'd0;
                            end
                        end
                        else if (mask[1] && idx_reg < 8'd8)
                            pend_next = {pend_reg[55:0], data_byte};
                        else if (mask[5] && idx_reg < 8'd3)
                            ebuf_next = {ebuf_reg[23:0], data_byte};
                    end
                    idx_next = idx_inc;
                    pos_next = (pos_reg == 3'd4) ? 3'd0 : pos_reg + 3'd1;
                    if (idx_inc == len_reg)
                    begin
                        commit     = 1'b1;
                        phase_next = PH_TAG;
                    end
                end
            endcase
        end
        if (commit && active)
        begin
            found_next = found_reg | mask;
            if (mask[0])
                ttx_next = pend_next[39:0] & 40'h7F_FFFF_FFFF;
            else if (mask[1])
            begin
                subv_next = commit_len >= 8'd8;
                sub_next  = (commit_len >= 8'd8) ? pend_next : 64'd0;
            end
            else if (mask[5])
            begin
                langv_next = commit_len >= 8'd3;
                lang_next  = (commit_len >= 8'd3) ? ebuf_next[23:0] : 24'd0;
            end
        end
    end

    always_comb
    begin
        sum_push            = in_take && last_byte;
        sum_word.kind       = stream_kind;
        sum_word.f_ttx      = found_next[0];
        sum_word.f_sub      = found_next[1];
        sum_word.f_ac3      = found_next[2];
        sum_word.f_eac3     = found_next[3];
        sum_word.f_ait      = found_next[4];
        sum_word.sub_valid  = subv_next;
        sum_word.lang_valid = langv_next;
        sum_word.ttx        = ttx_next;
        sum_word.sub        = sub_next;
        sum_word.lang       = lang_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG;
            tag_reg   <= 8'd0;
            len_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            found_reg <= 6'd0;
            ebuf_reg  <= 32'd0;
            pend_reg  <= 64'd0;
            ttx_reg   <= 40'd0;
            sub_reg   <= 64'd0;
            lang_reg  <= 24'd0;
            subv_reg  <= 1'b0;
            langv_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end
        else if (in_take && last_byte)
        begin
            // clear all per-stream state
            phase_reg <= PH_TAG;
            tag_reg   <= 8'd0;
            len_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            found_reg <= 6'd0;
            ebuf_reg  <= 32'd0;
            pend_reg  <= 64'd0;
            ttx_reg   <= 40'd0;
            sub_reg   <= 64'd0;
            lang_reg  <= 24'd0;
            subv_reg  <= 1'b0;
            langv_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            ebuf_reg  <= ebuf_next;
            pend_reg  <= pend_next;
            ttx_reg   <= ttx_next;
            sub_reg   <= sub_next;
            lang_reg  <= lang_next;
            subv_reg  <= subv_next;
            langv_reg <= langv_next;
            pos_reg   <= pos_next;
        end
    end

    `ESDC_ASSERT_NEXT(a_last_clears, in_take && last_byte, found_reg == 6'd0 && phase_reg == PH_TAG)
    `ESDC_ASSERT_IMP(a_pos_range, 1'b1, pos_reg <= 3'd4)
    `ESDC_ASSERT_IMP(a_subv_found, subv_reg, found_reg[1])
    `ESDC_ASSERT_IMP(a_langv_found, langv_reg, found_reg[5])

endmodule
`default_nettype wire

FILE: rtl/esdc_queue.sv
`default_nettype none
`include "es_descriptor_classifier_macros.svh"
module esdc_queue
    import esdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  summary_t  push_word,
    output logic      full,
    output logic      not_empty,
    input  wire logic pop,
    output summary_t  head_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    summary_t          mem [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = cnt_reg == (AW+1)'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head_word = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= bump(wr_reg);
            if (pop)
                rd_reg <= bump(rd_reg);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `ESDC_ASSERT_IMP(a_no_overflow, push && !pop, !full)
    `ESDC_ASSERT_IMP(a_no_underflow, pop, not_empty)
    `ESDC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= (AW+1)'(DEPTH))

endmodule
`default_nettype wire

FILE: rtl/esdc_back.sv
`default_nettype none
module esdc_back
    import esdc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  summary_t  head_word,
    input  wire logic head_valid,
    output logic      pop,
    input  wire logic out_stall,
    output logic      out_valid,
    output result_t   out_word
);

    result_t r;
    logic    valid_reg;
    result_t res_reg;

    always_comb
    begin
        r = '0;
        unique case (head_word.kind)
            SK_MPEG1V, SK_MPEG2V:
            begin
                r.stream_class = CLS_VID; r.codec_id = COD_M2V;
            end
            SK_H264: begin r.stream_class = CLS_VID; r.codec_id = COD_H264; end
            SK_HEVC: begin r.stream_class = CLS_VID; r.codec_id = COD_HEVC; end
            SK_MPEG1A, SK_MPEG2A:
            begin
                r.stream_class = CLS_AUD; r.codec_id = COD_MP2A;
            end
            SK_AAC:  begin r.stream_class = CLS_AUD; r.codec_id = COD_AAC; end
            SK_LATM: begin r.stream_class = CLS_AUD; r.codec_id = COD_LATM; end
            SK_AC3:  begin r.stream_class = CLS_AUD; r.codec_id = COD_AC3; end
            SK_EAC3: begin r.stream_class = CLS_AUD; r.codec_id = COD_EAC3; end
            SK_PES:
            begin
                if (head_word.f_ttx)
                begin
                    r.stream_class      = CLS_TTX;
                    r.teletext_page     = head_word.ttx[38:29];
                    r.teletext_kind     = head_word.ttx[28:24];
                    r.teletext_language = head_word.ttx[23:0];
                end
                else if (head_word.f_sub)
                begin
                    r.stream_class = CLS_SUB;
                    if (head_word.sub_valid)
                    begin
                        r.language         = head_word.sub[63:40];
                        r.subtitle_kind    = head_word.sub[39:32];
                        r.composition_page = head_word.sub[31:16];
                        r.ancillary_page   = head_word.sub[15:0];
                    end
                end
                else if (head_word.f_ac3)
                begin
                    r.stream_class = CLS_AUD; r.codec_id = COD_AC3;
                end
                else if (head_word.f_eac3)
                begin
                    r.stream_class = CLS_AUD; r.codec_id = COD_EAC3;
                end
            end
            SK_PRIV:
            begin
                if (head_word.f_ait)
                    r.stream_class = CLS_AIT;
            end
            default: r.stream_class = CLS_DATA;
        endcase
        if (head_word.lang_valid)
            r.language = head_word.lang;
    end

    // load the output register when a queue entry waits and the register is empty or being taken
    assign pop       = head_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;
    assign out_word  = res_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            res_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

endmodule
`default_nettype wire
